/* rtl/assert_macros.svh */
// assertion macros used by the checker in mtp_checker.sv
// expects clk_i and rst_ni in the scope that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define MTP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion lbl failed");

// signal holds its value on the edge after a condition
`define MTP_ASSERT_HOLD(lbl, cond, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error("assertion lbl failed");

`endif

/* rtl/mtp_pkg.sv */
// shared constants for the move toward point datapath
// no dependencies
package mtp_pkg;

  // radicand bits consumed by one square root stage
  localparam int unsigned ROOT_DIGIT_BITS = 2;

endpackage

/* rtl/mtp_if.sv */
// valid/ready channel interfaces for the move toward point block
// depends on nothing
interface mtp_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] dest_x;
  logic [COORD_BITS-1:0] dest_y;
  logic [COORD_BITS-1:0] travel;

  modport source (output valid, start_x, start_y, dest_x, dest_y, travel, input ready);
  modport sink (input valid, start_x, start_y, dest_x, dest_y, travel, output ready);
endinterface

interface mtp_out_if #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
);
  logic                            valid;
  logic                            ready;
  logic [COORD_BITS+FRAC_BITS-1:0] new_x;
  logic [COORD_BITS+FRAC_BITS-1:0] new_y;
  logic                            arrived;

  modport source (output valid, new_x, new_y, arrived, input ready);
  modport sink (input valid, new_x, new_y, arrived, output ready);
endinterface

/* rtl/move_toward_point.sv */
// move toward point: pipelined distance, compare and scaled step per axis
// depends on mtp_pkg and the channel interfaces in mtp_if.sv
//
//   channel | dir | payload
//   in_i    | in  | start_x, start_y, dest_x, dest_y, travel
//   out_o   | out | new_x, new_y, arrived
//
// one beat accepted per cycle unless out_o stalls; the pipeline holds 3 + (C+F+1) root
// stages + 1 multiply stage + (C+F) divide stages + 1 output stage
// the root and divider loops are unrolled one bit per register stage
// reset clears the stage valid bits only; no clearing pass
// the whole pipeline advances when the output register is empty or taken,
// so a stall freezes every stage and in_i.ready is high when out_o is empty or taken
module move_toward_point #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mtp_in_if.sink   in_i,
  mtp_out_if.source out_o
);

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned FW   = FRAC_BITS;
  localparam int unsigned OW   = CW + FW;
  localparam int unsigned QW   = CW + FW + 1;
  localparam int unsigned SW   = 2 * CW + 1;
  localparam int unsigned RADW = 2 * QW;
  localparam int unsigned DB   = mtp_pkg::ROOT_DIGIT_BITS;

  typedef struct packed {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] dx;
    logic [CW-1:0] dy;
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [CW-1:0] tr;
  } side_t;

  logic en;

  // pipeline advances when the output slot is free
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // stage 0: register beat with absolute deltas
  logic  v0_q;
  side_t s0_q, s0_d;

  always_comb begin
    s0_d.sx = in_i.start_x;
    s0_d.sy = in_i.start_y;
    s0_d.dx = in_i.dest_x;
    s0_d.dy = in_i.dest_y;
    s0_d.tr = in_i.travel;
    s0_d.ax = (in_i.dest_x >= in_i.start_x) ? in_i.dest_x - in_i.start_x
                                             : in_i.start_x - in_i.dest_x;
    s0_d.ay = (in_i.dest_y >= in_i.start_y) ? in_i.dest_y - in_i.start_y
                                             : in_i.start_y - in_i.dest_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
    end
  end

  // stage 1: squares
  logic          v1_q;
  side_t         s1_q;
  logic [2*CW-1:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s0_q;
      sqx_q <= s0_q.ax * s0_q.ax;
      sqy_q <= s0_q.ay * s0_q.ay;
    end
  end

  // stage 2: radicand, sum scaled by two fraction fields
  logic            rv_q [QW+1];
  side_t           rs_q [QW+1];
  logic [QW-1:0]   rt_q [QW+1];
  logic [QW+1:0]   rm_q [QW+1];
  logic [RADW-1:0] rd_q [QW+1];
  logic [SW-1:0]   sum_sq;

  assign sum_sq = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q[0] <= 1'b0;
    end else if (en) begin
      rv_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rs_q[0] <= s1_q;
      rt_q[0] <= '0;
      rm_q[0] <= '0;
      rd_q[0] <= {1'b0, sum_sq, {(2*FW){1'b0}}};
    end
  end

  // square root: one root bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_root
    logic [QW+1:0] rem2;
    logic [QW+1:0] trial;
    logic          take;

    assign rem2  = {rm_q[k][QW-1:0], rd_q[k][RADW-1 -: DB]};
    assign trial = {rt_q[k], 2'b01};
    assign take  = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[k+1] <= 1'b0;
      end else if (en) begin
        rv_q[k+1] <= rv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rs_q[k+1] <= rs_q[k];
        rd_q[k+1] <= rd_q[k] << DB;
        rm_q[k+1] <= take ? rem2 - trial : rem2;
        rt_q[k+1] <= {rt_q[k][QW-2:0], take};
      end
    end
  end

  // compare with allowed travel and scale both deltas
  logic [OW-1:0]   allowed;
  logic [2*OW-1:0] prodx_d, prody_d;

  assign allowed = {rs_q[QW].tr, {FW{1'b1}}};
  assign prodx_d = {rs_q[QW].ax, {FW{1'b0}}} * allowed;
  assign prody_d = {rs_q[QW].ay, {FW{1'b0}}} * allowed;

  logic          dv_q   [OW+1];
  side_t         ds_q   [OW+1];
  logic          darr_q [OW+1];
  logic [QW-1:0] dist_q [OW+1];
  logic [QW:0]   rx_q   [OW+1];
  logic [QW:0]   ry_q   [OW+1];
  logic [OW-1:0] px_q   [OW+1];
  logic [OW-1:0] py_q   [OW+1];
  logic [OW-1:0] qx_q   [OW+1];
  logic [OW-1:0] qy_q   [OW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= rv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_q[0]   <= rs_q[QW];
      darr_q[0] <= {1'b0, rt_q[QW]} < {2'b00, allowed};
      dist_q[0] <= rt_q[QW];
      rx_q[0]   <= {2'b00, prodx_d[2*OW-1:OW]};
      ry_q[0]   <= {2'b00, prody_d[2*OW-1:OW]};
      px_q[0]   <= prodx_d[OW-1:0];
      py_q[0]   <= prody_d[OW-1:0];
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
    end
  end

  // restoring division: one quotient bit per stage for each axis
  for (genvar j = 0; j < OW; j++) begin : g_div
    logic [QW:0] tx, ty;
    logic        gx, gy;

    assign tx = {rx_q[j][QW-1:0], px_q[j][OW-1]};
    assign ty = {ry_q[j][QW-1:0], py_q[j][OW-1]};
    assign gx = tx >= {1'b0, dist_q[j]};
    assign gy = ty >= {1'b0, dist_q[j]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ds_q[j+1]   <= ds_q[j];
        darr_q[j+1] <= darr_q[j];
        dist_q[j+1] <= dist_q[j];
        rx_q[j+1]   <= gx ? tx - {1'b0, dist_q[j]} : tx;
        ry_q[j+1]   <= gy ? ty - {1'b0, dist_q[j]} : ty;
        px_q[j+1]   <= px_q[j] << 1;
        py_q[j+1]   <= py_q[j] << 1;
        qx_q[j+1]   <= {qx_q[j][OW-2:0], gx};
        qy_q[j+1]   <= {qy_q[j][OW-2:0], gy};
      end
    end
  end

  // final position per axis
  side_t         fs;
  logic [OW-1:0] basex, basey, destx, desty, nx_d, ny_d;

  assign fs    = ds_q[OW];
  assign basex = {fs.sx, {FW{1'b0}}};
  assign basey = {fs.sy, {FW{1'b0}}};
  assign destx = {fs.dx, {FW{1'b0}}};
  assign desty = {fs.dy, {FW{1'b0}}};

  always_comb begin
    if (darr_q[OW]) begin
      nx_d = destx;
      ny_d = desty;
    end else begin
      if (fs.dx >= fs.sx) begin
        nx_d = basex + qx_q[OW];
      end else begin
        nx_d = (qx_q[OW] > basex) ? '0 : basex - qx_q[OW];
      end
      if (fs.dy >= fs.sy) begin
        ny_d = basey + qy_q[OW];
      end else begin
        ny_d = (qy_q[OW] > basey) ? '0 : basey - qy_q[OW];
      end
    end
  end

  // output register
  logic          ov_q;
  logic [OW-1:0] ox_q, oy_q;
  logic          oa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv_q[OW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q <= nx_d;
      oy_q <= ny_d;
      oa_q <= darr_q[OW];
    end
  end

  assign out_o.valid   = ov_q;
  assign out_o.new_x   = ox_q;
  assign out_o.new_y   = oy_q;
  assign out_o.arrived = oa_q;

endmodule

/* rtl/mtp_checker.sv */
// port-level checks for move_toward_point, bound to the top level
// depends on assert_macros.svh and the top level's channel ports
`include "assert_macros.svh"

module mtp_checker #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [COORD_BITS+FRAC_BITS-1:0] new_x_i,
  input logic [COORD_BITS+FRAC_BITS-1:0] new_y_i,
  input logic                            arrived_i
);

  logic frac_zero;

  // both positions carry no fraction bits
  assign frac_zero = (new_x_i[FRAC_BITS-1:0] == '0) && (new_y_i[FRAC_BITS-1:0] == '0);

  // an empty output slot never blocks the input
  `MTP_ASSERT(a_ready_when_empty, !out_valid_i |-> in_ready_i)

  // arrival lands on whole coordinates
  `MTP_ASSERT(a_arrive_whole, out_valid_i && arrived_i |-> frac_zero)

  // stalled beat keeps valid and its new_x payload
  `MTP_ASSERT(a_valid_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `MTP_ASSERT_HOLD(a_x_hold, out_valid_i && !out_ready_i, new_x_i)

endmodule

bind move_toward_point mtp_checker #(
  .COORD_BITS(COORD_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_mtp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .new_x_i    (out_o.new_x),
  .new_y_i    (out_o.new_y),
  .arrived_i  (out_o.arrived)
);

/* dv/move_toward_point_tb.sv */
// self-checking testbench for move_toward_point: directed table, then random beats
// depends on rtl/mtp_if.sv and rtl/move_toward_point.sv
module move_toward_point_tb;

  localparam int unsigned CB = 16;
  localparam int unsigned FB = 8;
  localparam int unsigned OW = CB + FB;
  localparam int unsigned LATENCY = 54;
  localparam int unsigned N_RANDOM = 1700;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CB-1:0] sx;
    logic [CB-1:0] sy;
    logic [CB-1:0] dx;
    logic [CB-1:0] dy;
    logic [CB-1:0] tr;
  } move_req_t;

  typedef struct packed {
    logic [OW-1:0] nx;
    logic [OW-1:0] ny;
    logic          arr;
  } move_res_t;

  // one directed row; has_res marks a result typed in by hand
  typedef struct packed {
    move_req_t req;
    logic      has_res;
    move_res_t res;
  } move_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   failed = 1'b0;
  longint unsigned cycle_cnt = 0;
  move_res_t pending_moves[$];
  move_row_t rows[$];

  mtp_in_if  #(.COORD_BITS(CB)) in_ch ();
  mtp_out_if #(.COORD_BITS(CB), .FRAC_BITS(FB)) out_ch ();

  move_toward_point #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bitwise integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [OW-1:0] axis_step(longint unsigned s, longint unsigned d,
                                               longint unsigned allowed,
                                               longint unsigned span);
    longint unsigned base;
    longint unsigned mag;
    longint unsigned mv;
    base = s << FB;
    mag = ((d >= s) ? d - s : s - d) << FB;
    if (span == 0) return OW'(d << FB);
    mv = (mag * allowed) / span;
    if (d >= s) return OW'(base + mv);
    return OW'((mv > base) ? 0 : base - mv);
  endfunction

  function automatic move_res_t predict_move(move_req_t q);
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned span;
    longint unsigned allowed;
    move_res_t r;
    ax = (q.sx >= q.dx) ? q.sx - q.dx : q.dx - q.sx;
    ay = (q.sy >= q.dy) ? q.sy - q.dy : q.dy - q.sy;
    span = isqrt((ax * ax + ay * ay) << (2 * FB));
    allowed = ((longint'(q.tr) + 1) << FB) - 1;
    if (span < allowed) begin
      r.nx = OW'(longint'(q.dx) << FB);
      r.ny = OW'(longint'(q.dy) << FB);
      r.arr = 1'b1;
    end else begin
      r.nx = axis_step(q.sx, q.dx, allowed, span);
      r.ny = axis_step(q.sy, q.dy, allowed, span);
      r.arr = 1'b0;
    end
    return r;
  endfunction

  function automatic move_req_t rand_req();
    move_req_t q;
    logic [95:0] raw;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    raw = {$urandom(), $urandom(), $urandom()};
    q = raw[79:0];
    // half the beats use nearby destinations so both outcomes show up
    if (mode < 5) begin
      q.dx = q.sx + CB'($urandom_range(0, 600)) - CB'(300);
      q.dy = q.sy + CB'($urandom_range(0, 600)) - CB'(300);
      q.tr = CB'($urandom_range(0, 400));
    end else if (mode < 7) begin
      q.tr = CB'($urandom_range(0, 2000));
    end else if (mode == 7) begin
      q.dx = q.sx;
    end
    return q;
  endfunction

  // sender: bursts with random gaps
  task automatic send_beat(move_req_t q);
    in_ch.valid <= 1'b1;
    in_ch.start_x <= q.sx;
    in_ch.start_y <= q.sy;
    in_ch.dest_x <= q.dx;
    in_ch.dest_y <= q.dy;
    in_ch.travel <= q.tr;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_moves.push_back(predict_move(q));
  endtask

  task automatic maybe_gap(ref int unsigned burst_left);
    int unsigned g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (g != 0) begin
        in_ch.valid <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // receiver stall pattern and checker
  logic [15:0] stall_pat;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_pat <= 16'hb5c3;
      out_ch.ready <= 1'b0;
    end else begin
      stall_pat <= {stall_pat[14:0],
                    stall_pat[15] ^ stall_pat[13] ^ stall_pat[12] ^ stall_pat[10]};
      out_ch.ready <= (cycle_cnt[11:9] == 3'd2) ? 1'b1 : (stall_pat[2:0] != 3'd0);
    end
  end

  always @(posedge clk_i) begin
    move_res_t got;
    move_res_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{nx: out_ch.new_x, ny: out_ch.new_y, arr: out_ch.arrived};
      if (pending_moves.size() == 0) begin
        $display("%0t: unexpected beat x=%h y=%h arrived=%b", $time,
                 got.nx, got.ny, got.arr);
        failed = 1'b1;
      end else begin
        want = pending_moves.pop_front();
        if (got.nx !== want.nx) begin
          $display("%0t: new_x expected %h actual %h", $time, want.nx, got.nx);
          failed = 1'b1;
        end
        if (got.ny !== want.ny) begin
          $display("%0t: new_y expected %h actual %h", $time, want.ny, got.ny);
          failed = 1'b1;
        end
        if (got.arr !== want.arr) begin
          $display("%0t: arrived expected %b actual %b", $time, want.arr, got.arr);
          failed = 1'b1;
        end
      end
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic move_row_t row(int sx, int sy, int dx, int dy, int tr,
                                    logic known, int nx, int ny, logic arr);
    move_row_t w;
    w.req = '{sx: CB'(sx), sy: CB'(sy), dx: CB'(dx), dy: CB'(dy), tr: CB'(tr)};
    w.has_res = known;
    w.res = '{nx: OW'(nx), ny: OW'(ny), arr: arr};
    return w;
  endfunction

  initial begin
    int unsigned burst_left;
    move_row_t w;
    int unsigned drain;
    in_ch.valid = 1'b0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.dest_x = '0;
    in_ch.dest_y = '0;
    in_ch.travel = '0;
    burst_left = 0;

    // same point, zero travel, extremes, one-axis, diagonal and short moves
    rows.push_back(row(0, 0, 0, 0, 0, 1, 0, 0, 1));
    rows.push_back(row(65535, 65535, 65535, 65535, 65535, 1, 24'hffff00, 24'hffff00, 1));
    rows.push_back(row(100, 200, 100, 200, 0, 1, 100 << 8, 200 << 8, 1));
    rows.push_back(row(0, 0, 65535, 0, 65535, 1, 24'hffff00, 0, 1));
    rows.push_back(row(0, 0, 0, 65535, 0, 0, 0, 0, 0));
    rows.push_back(row(65535, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(0, 0, 65535, 65535, 65535, 0, 0, 0, 0));
    rows.push_back(row(65535, 65535, 0, 0, 65535, 0, 0, 0, 0));
    rows.push_back(row(65535, 65535, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(0, 65535, 65535, 0, 1000, 0, 0, 0, 0));
    rows.push_back(row(10, 10, 12, 10, 1, 0, 0, 0, 0));
    rows.push_back(row(10, 10, 11, 10, 0, 0, 0, 0, 0));
    rows.push_back(row(10, 10, 13, 14, 4, 0, 0, 0, 0));
    rows.push_back(row(10, 10, 13, 14, 5, 0, 0, 0, 0));
    rows.push_back(row(50, 50, 50, 0, 10, 0, 0, 0, 0));
    rows.push_back(row(300, 7, 3, 7, 100, 0, 0, 0, 0));
    rows.push_back(row(21845, 43690, 43690, 21845, 43690, 0, 0, 0, 0));
    rows.push_back(row(43690, 21845, 21845, 43690, 21845, 0, 0, 0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      w = rows[i];
      maybe_gap(burst_left);
      send_beat(w.req);
      // hand-typed results replace the predicted one for those rows
      if (w.has_res) pending_moves[pending_moves.size() - 1] = w.res;
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      maybe_gap(burst_left);
      send_beat(rand_req());
    end
    in_ch.valid <= 1'b0;

    while (pending_moves.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 4 * LATENCY) begin
      @(posedge clk_i);
      drain++;
    end
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/mtp_pkg.sv
rtl/mtp_if.sv
rtl/move_toward_point.sv
rtl/mtp_checker.sv
dv/move_toward_point_tb.sv
